>>> rtl/qkvls_pkg.sv
// shared codes, limits and byte class functions for the key/value line scanner
package qkvls_pkg;

  localparam int NameLimitDefault  = 32;
  localparam int ValueLimitDefault = 64;

  localparam int CountWidth = 7;

  // result kinds
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd0;
  localparam logic [2:0] KIND_NAME_END   = 3'd1;
  localparam logic [2:0] KIND_VALUE_BYTE = 3'd2;
  localparam logic [2:0] KIND_LINE_DONE  = 3'd3;
  localparam logic [2:0] KIND_STREAM_END = 3'd4;
  localparam logic [2:0] KIND_ERROR      = 3'd5;

  // error causes
  localparam logic [1:0] CAUSE_UNEXPECTED = 2'd0;
  localparam logic [1:0] CAUSE_NAME_LONG  = 2'd1;
  localparam logic [1:0] CAUSE_VALUE_LONG = 2'd2;
  localparam logic [1:0] CAUSE_EARLY_END  = 2'd3;

  localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_DASH       = 8'h2D;
  localparam logic [7:0] CHAR_QUOTE      = 8'h27;
  localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic starts_name(input logic [7:0] b);
    starts_name = is_letter(b) || (b == CHAR_UNDERSCORE);
  endfunction

  function automatic logic continues_name(input logic [7:0] b);
    continues_name = is_letter(b) || is_digit(b) || (b == CHAR_UNDERSCORE) ||
                     (b == CHAR_DASH);
  endfunction

endpackage

>>> rtl/qkvls_if.sv
// request channels of the key/value line scanner: bytes in, tokens out
interface qkvls_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface qkvls_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] char_out;
  logic [1:0] error_cause;

  modport source (output valid, output kind, output char_out, output error_cause,
                  input ready);
  modport sink   (input valid, input kind, input char_out, input error_cause,
                  output ready);
endinterface

>>> rtl/quoted_key_value_line_scanner_core.sv
// Scanner for lines of the form name = 'value', one byte or end mark per request.
// The block takes one request every clock cycle. A request is held in an input
// register and then decoded against the current phase in one step of short
// logic; a token, where the request makes one, is then written to the output
// register. Requests that make no token (blanks, the '=', the opening quote, a
// backslash) still pass through the input register. Only a stalled output
// slows the input: it stops when the input register holds a request and the
// output register holds a token that is not yet taken. After a stream end or an
// error token the block takes further requests and drops them until reset.
module quoted_key_value_line_scanner_core #(
  parameter int NAME_LIMIT  = qkvls_pkg::NameLimitDefault,
  parameter int VALUE_LIMIT = qkvls_pkg::ValueLimitDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  qkvls_byte_if.sink           byte_stream,
  qkvls_token_if.source        tokens
);

  localparam int Cw = qkvls_pkg::CountWidth;
  localparam logic [Cw-1:0] NameMax  = Cw'(NAME_LIMIT);
  localparam logic [Cw-1:0] ValueMax = Cw'(VALUE_LIMIT);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_NAME       = 3'd1;
  localparam logic [2:0] PH_AFTER_NAME = 3'd2;
  localparam logic [2:0] PH_AFTER_EQ   = 3'd3;
  localparam logic [2:0] PH_VALUE      = 3'd4;
  localparam logic [2:0] PH_ESCAPE     = 3'd5;
  localparam logic [2:0] PH_ENDED      = 3'd6;
  localparam logic [2:0] PH_ERROR      = 3'd7;

  logic          stage_valid;
  logic [7:0]    stage_byte;
  logic          stage_end;

  logic [2:0]    phase, phase_next;
  logic [Cw-1:0] field_count, field_count_next;

  logic          out_valid;
  logic [2:0]    out_kind;
  logic [7:0]    out_char;
  logic [1:0]    out_cause;

  logic          res;
  logic [2:0]    res_kind;
  logic [7:0]    res_char;
  logic [1:0]    res_cause;

  logic          out_free;
  logic          process;
  logic          take_in;

  assign out_free = !out_valid || tokens.ready;
  assign process  = stage_valid && out_free;
  assign byte_stream.ready = !stage_valid || process;
  assign take_in  = byte_stream.valid && byte_stream.ready;

  assign tokens.valid       = out_valid;
  assign tokens.kind        = out_kind;
  assign tokens.char_out    = out_char;
  assign tokens.error_cause = out_cause;

  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    res              = 1'b0;
    res_kind         = qkvls_pkg::KIND_ERROR;
    res_char         = 8'd0;
    res_cause        = qkvls_pkg::CAUSE_UNEXPECTED;
    if (phase == PH_ENDED || phase == PH_ERROR) begin
      res = 1'b0;
    end else if (stage_end) begin
      res = 1'b1;
      if (phase == PH_IDLE) begin
        phase_next = PH_ENDED;
        res_kind   = qkvls_pkg::KIND_STREAM_END;
      end else begin
        phase_next = PH_ERROR;
        res_cause  = qkvls_pkg::CAUSE_EARLY_END;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (qkvls_pkg::starts_name(stage_byte)) begin
            field_count_next = Cw'(1);
            phase_next       = PH_NAME;
            res              = 1'b1;
            res_kind         = qkvls_pkg::KIND_NAME_BYTE;
            res_char         = stage_byte;
          end else if (!qkvls_pkg::is_blank(stage_byte)) begin
            phase_next = PH_ERROR;
            res        = 1'b1;
          end
        end
        PH_NAME: begin
          res = 1'b1;
          if (qkvls_pkg::continues_name(stage_byte)) begin
            if (field_count >= NameMax) begin
              phase_next = PH_ERROR;
              res_cause  = qkvls_pkg::CAUSE_NAME_LONG;
            end else begin
              field_count_next = field_count + Cw'(1);
              res_kind         = qkvls_pkg::KIND_NAME_BYTE;
              res_char         = stage_byte;
            end
          end else if (qkvls_pkg::is_blank(stage_byte)) begin
            phase_next = PH_AFTER_NAME;
            res_kind   = qkvls_pkg::KIND_NAME_END;
          end else if (stage_byte == qkvls_pkg::CHAR_EQUALS) begin
            phase_next = PH_AFTER_EQ;
            res_kind   = qkvls_pkg::KIND_NAME_END;
          end else begin
            phase_next = PH_ERROR;
          end
        end
        PH_AFTER_NAME: begin
          if (stage_byte == qkvls_pkg::CHAR_EQUALS) begin
            phase_next = PH_AFTER_EQ;
          end else if (!qkvls_pkg::is_blank(stage_byte)) begin
            phase_next = PH_ERROR;
            res        = 1'b1;
          end
        end
        PH_AFTER_EQ: begin
          if (stage_byte == qkvls_pkg::CHAR_QUOTE) begin
            field_count_next = '0;
            phase_next       = PH_VALUE;
          end else if (!qkvls_pkg::is_blank(stage_byte)) begin
            phase_next = PH_ERROR;
            res        = 1'b1;
          end
        end
        PH_VALUE: begin
          if (stage_byte == qkvls_pkg::CHAR_QUOTE) begin
            field_count_next = '0;
            phase_next       = PH_IDLE;
            res              = 1'b1;
            res_kind         = qkvls_pkg::KIND_LINE_DONE;
          end else if (field_count >= ValueMax) begin
            phase_next = PH_ERROR;
            res        = 1'b1;
            res_cause  = qkvls_pkg::CAUSE_VALUE_LONG;
          end else if (stage_byte == qkvls_pkg::CHAR_BACKSLASH) begin
            phase_next = PH_ESCAPE;
          end else begin
            field_count_next = field_count + Cw'(1);
            res              = 1'b1;
            res_kind         = qkvls_pkg::KIND_VALUE_BYTE;
            res_char         = stage_byte;
          end
        end
        PH_ESCAPE: begin
          // escaped byte is always kept
          field_count_next = field_count + Cw'(1);
          phase_next       = PH_VALUE;
          res              = 1'b1;
          res_kind         = qkvls_pkg::KIND_VALUE_BYTE;
          res_char         = stage_byte;
        end
        default: begin
          res = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      phase       <= PH_IDLE;
      field_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take_in) begin
        stage_valid <= 1'b1;
      end else if (process) begin
        stage_valid <= 1'b0;
      end
      if (process) begin
        phase       <= phase_next;
        field_count <= field_count_next;
      end
      if (process && res) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      stage_byte <= byte_stream.byte_in;
      stage_end  <= byte_stream.end_of_input;
    end
    if (process && res) begin
      out_kind  <= res_kind;
      out_char  <= res_char;
      out_cause <= res_cause;
    end
  end

endmodule

>>> rtl/qkvls_checker.sv
// port checks for the key/value line scanner, bound to the scanner core
module qkvls_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] char_out,
  input logic [1:0] error_cause
);

  logic finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b0;
    end else if (out_valid && out_ready &&
                 (kind == qkvls_pkg::KIND_ERROR || kind == qkvls_pkg::KIND_STREAM_END)) begin
      finished <= 1'b1;
    end
  end

  // a stalled token holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out) &&
    $stable(error_cause))
    else $error("token changed while stalled");

  // nothing follows a stream end or an error
  a_silent_after_end: assert property (@(posedge clk) disable iff (rst)
    finished |-> !out_valid)
    else $error("token after stream end or error");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= qkvls_pkg::KIND_ERROR)
    else $error("token kind out of range");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != qkvls_pkg::KIND_NAME_BYTE && kind != qkvls_pkg::KIND_VALUE_BYTE
    |-> char_out == 8'd0)
    else $error("marker token carries a byte");

  a_cause_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != qkvls_pkg::KIND_ERROR |-> error_cause == 2'd0)
    else $error("cause set on a non-error token");

endmodule

bind quoted_key_value_line_scanner_core qkvls_checker u_qkvls_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .kind        (tokens.kind),
  .char_out    (tokens.char_out),
  .error_cause (tokens.error_cause)
);

>>> tb/sv/tb_top.sv
// self-checking testbench for the quoted key/value line scanner core
`timescale 1ns / 1ps

module tb_top;

  localparam int NAME_LIM    = qkvls_pkg::NameLimitDefault;
  localparam int VAL_LIM     = qkvls_pkg::ValueLimitDefault;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 150;
  localparam int QUIET_TAIL  = 150;
  localparam int RANDOM_BYTES = 1500;

  typedef enum logic [2:0] {
    S_BETWEEN, S_NAME, S_POST_NAME, S_POST_EQ, S_VALUE, S_ESCAPE, S_ENDED, S_FAULTED
  } scan_phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [1:0] cause;
  } token_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       drain;
  } byte_req_t;

  logic clk;
  logic rst;

  qkvls_byte_if  byte_ch ();
  qkvls_token_if tok_ch ();

  quoted_key_value_line_scanner_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_ch),
    .tokens      (tok_ch)
  );

  byte_req_t bytes_to_send[$];
  token_t    tokens_due[$];

  scan_phase_t                      scan_ph;
  logic [qkvls_pkg::CountWidth-1:0] kept;

  logic in_taken;
  int   in_count;
  int   send_gap;
  int   sink_gap;
  int   long_hold;
  logic hold_done;
  int   quiet_cycles;
  int   mismatches;
  logic drain_next;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte classes
  function automatic logic white(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic name_head(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A], qkvls_pkg::CHAR_UNDERSCORE};
  endfunction

  function automatic logic name_tail(input logic [7:0] b);
    return name_head(b) || (b inside {[8'h30:8'h39], qkvls_pkg::CHAR_DASH});
  endfunction

  function automatic token_t fault(input logic [1:0] c);
    scan_ph = S_FAULTED;
    return '{kind: qkvls_pkg::KIND_ERROR, ch: 8'h00, cause: c};
  endfunction

  // expected token for one accepted request; returns 0 when none is made
  function automatic logic scan_byte(input logic [7:0] b, input logic fin, output token_t t);
    logic hit;
    hit = 1'b1;
    t = '{kind: qkvls_pkg::KIND_NAME_BYTE, ch: 8'h00, cause: qkvls_pkg::CAUSE_UNEXPECTED};
    if (scan_ph == S_ENDED || scan_ph == S_FAULTED) begin
      hit = 1'b0;
    end else if (fin) begin
      if (scan_ph == S_BETWEEN) begin
        t.kind = qkvls_pkg::KIND_STREAM_END;
        scan_ph = S_ENDED;
      end else begin
        t = fault(qkvls_pkg::CAUSE_EARLY_END);
      end
    end else begin
      case (scan_ph)
        S_BETWEEN: begin
          if (name_head(b)) begin
            kept = qkvls_pkg::CountWidth'(1);
            scan_ph = S_NAME;
            t.ch = b;
          end else if (white(b)) begin
            hit = 1'b0;
          end else begin
            t = fault(qkvls_pkg::CAUSE_UNEXPECTED);
          end
        end
        S_NAME: begin
          if (name_tail(b)) begin
            if (kept >= NAME_LIM) begin
              t = fault(qkvls_pkg::CAUSE_NAME_LONG);
            end else begin
              kept = kept + 1'b1;
              t.ch = b;
            end
          end else if (white(b) || b == qkvls_pkg::CHAR_EQUALS) begin
            t.kind = qkvls_pkg::KIND_NAME_END;
            scan_ph = white(b) ? S_POST_NAME : S_POST_EQ;
          end else begin
            t = fault(qkvls_pkg::CAUSE_UNEXPECTED);
          end
        end
        S_POST_NAME: begin
          if (b == qkvls_pkg::CHAR_EQUALS) begin
            scan_ph = S_POST_EQ;
            hit = 1'b0;
          end else if (white(b)) begin
            hit = 1'b0;
          end else begin
            t = fault(qkvls_pkg::CAUSE_UNEXPECTED);
          end
        end
        S_POST_EQ: begin
          if (b == qkvls_pkg::CHAR_QUOTE) begin
            kept = '0;
            scan_ph = S_VALUE;
            hit = 1'b0;
          end else if (white(b)) begin
            hit = 1'b0;
          end else begin
            t = fault(qkvls_pkg::CAUSE_UNEXPECTED);
          end
        end
        S_VALUE: begin
          if (b == qkvls_pkg::CHAR_QUOTE) begin
            kept = '0;
            scan_ph = S_BETWEEN;
            t.kind = qkvls_pkg::KIND_LINE_DONE;
          end else if (kept >= VAL_LIM) begin
            t = fault(qkvls_pkg::CAUSE_VALUE_LONG);
          end else if (b == qkvls_pkg::CHAR_BACKSLASH) begin
            scan_ph = S_ESCAPE;
            hit = 1'b0;
          end else begin
            kept = kept + 1'b1;
            t.kind = qkvls_pkg::KIND_VALUE_BYTE;
            t.ch = b;
          end
        end
        S_ESCAPE: begin
          // escaped byte is kept whatever the count
          kept = kept + 1'b1;
          scan_ph = S_VALUE;
          t.kind = qkvls_pkg::KIND_VALUE_BYTE;
          t.ch = b;
        end
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

  // stimulus building
  function automatic void add(input logic [7:0] b, input logic fin = 1'b0);
    bytes_to_send.push_back('{b: b, fin: fin, drain: drain_next});
    drain_next = 1'b0;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endfunction

  function automatic logic [7:0] rand_head();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'h41 + r[7:0];
    if (r < 52) return 8'h61 + r[7:0] - 8'd26;
    return qkvls_pkg::CHAR_UNDERSCORE;
  endfunction

  function automatic logic [7:0] rand_tail();
    int r;
    r = $urandom_range(0, 63);
    if (r < 52) return rand_head();
    if (r < 62) return 8'h30 + r[7:0] - 8'd52;
    return (r == 62) ? qkvls_pkg::CHAR_UNDERSCORE : qkvls_pkg::CHAR_DASH;
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'h20 : 8'h08 + r[7:0];
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == qkvls_pkg::CHAR_QUOTE || b == qkvls_pkg::CHAR_BACKSLASH);
    return b;
  endfunction

  function automatic void add_name(input int len);
    add(rand_head());
    repeat (len - 1) add(rand_tail());
  endfunction

  function automatic void add_line(input int nlen, input int vlen);
    logic [7:0] e;
    repeat ($urandom_range(0, 2)) add(rand_blank());
    add_name(nlen);
    repeat ($urandom_range(0, 2)) add(rand_blank());
    add(qkvls_pkg::CHAR_EQUALS);
    repeat ($urandom_range(0, 2)) add(rand_blank());
    add(qkvls_pkg::CHAR_QUOTE);
    for (int i = 0; i < vlen; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        e = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
          e = $urandom_range(0, 1) ? qkvls_pkg::CHAR_QUOTE : qkvls_pkg::CHAR_BACKSLASH;
        add(qkvls_pkg::CHAR_BACKSLASH);
        add(e);
      end else begin
        add(rand_plain());
      end
    end
    add(qkvls_pkg::CHAR_QUOTE);
    if ($urandom_range(0, 2) != 0) add(8'h0A);
  endfunction

  // the one terminal event of the run, then requests that must be dropped
  function automatic void add_ending();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: begin
        repeat ($urandom_range(0, 2)) add(rand_blank());
        add(8'($urandom_range(0, 255)), 1'b1);
      end
      1: begin
        add_name($urandom_range(1, 4));
        case ($urandom_range(0, 4))
          0: ;
          1: add(rand_blank());
          2: add(qkvls_pkg::CHAR_EQUALS);
          3: begin
            add(qkvls_pkg::CHAR_EQUALS);
            add(qkvls_pkg::CHAR_QUOTE);
            repeat ($urandom_range(0, 3)) add(rand_plain());
          end
          default: begin
            add(qkvls_pkg::CHAR_EQUALS);
            add(qkvls_pkg::CHAR_QUOTE);
            add(qkvls_pkg::CHAR_BACKSLASH);
          end
        endcase
        add(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        case ($urandom_range(0, 3))
          0: do b = 8'($urandom_range(0, 255)); while (name_head(b) || white(b));
          1: begin
            add_name($urandom_range(1, 4));
            do b = 8'($urandom_range(0, 255));
            while (name_tail(b) || white(b) || b == qkvls_pkg::CHAR_EQUALS);
          end
          2: begin
            add_name($urandom_range(1, 4));
            add(rand_blank());
            do b = 8'($urandom_range(0, 255));
            while (white(b) || b == qkvls_pkg::CHAR_EQUALS);
          end
          default: begin
            add_name($urandom_range(1, 4));
            add(qkvls_pkg::CHAR_EQUALS);
            do b = 8'($urandom_range(0, 255));
            while (white(b) || b == qkvls_pkg::CHAR_QUOTE);
          end
        endcase
        add(b);
      end
      3: add_name(NAME_LIM + 1);
      default: begin
        add_name($urandom_range(1, 4));
        add(qkvls_pkg::CHAR_EQUALS);
        add(qkvls_pkg::CHAR_QUOTE);
        repeat (VAL_LIM) add(rand_plain());
        do b = 8'($urandom_range(0, 255)); while (b == qkvls_pkg::CHAR_QUOTE);
        add(b);
      end
    endcase
    repeat (20) add(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    add(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // driver: one request offered at a time, held until taken
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid        <= 1'b0;
      byte_ch.byte_in      <= 8'h00;
      byte_ch.end_of_input <= 1'b0;
    end else if (!byte_ch.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        byte_ch.valid <= 1'b0;
      end else if (bytes_to_send.size() != 0 &&
                   !(bytes_to_send[0].drain && tokens_due.size() != 0)) begin
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_in      <= bytes_to_send[0].b;
        byte_ch.end_of_input <= bytes_to_send[0].fin;
        void'(bytes_to_send.pop_front());
        if (bytes_to_send.size() > QUIET_TAIL && (in_count / 128) % 3 != 2 &&
            $urandom_range(0, 5) == 0)
          send_gap <= $urandom_range(1, 9);
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      tok_ch.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold    <= long_hold - 1;
      tok_ch.ready <= 1'b0;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      long_hold    <= HOLD_LEN;
      hold_done    <= 1'b1;
      tok_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap     <= sink_gap - 1;
      tok_ch.ready <= 1'b0;
    end else begin
      tok_ch.ready <= 1'b1;
      if (bytes_to_send.size() > QUIET_TAIL && (in_count / 160) % 3 != 0 &&
          $urandom_range(0, 5) == 0)
        sink_gap <= $urandom_range(1, 9);
    end
  end

  // accepted requests feed the predictor
  always @(posedge clk) begin
    token_t t;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= byte_ch.valid && byte_ch.ready;
      if (byte_ch.valid && byte_ch.ready) begin
        in_count <= in_count + 1;
        if (scan_byte(byte_ch.byte_in, byte_ch.end_of_input, t)) tokens_due.push_back(t);
      end
    end
  end

  // accepted tokens against the oldest prediction
  always @(posedge clk) begin
    token_t want;
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      if (tokens_due.size() == 0) begin
        report($sformatf("unexpected token kind %0d char %02h cause %0d",
                         tok_ch.kind, tok_ch.char_out, tok_ch.error_cause));
      end else begin
        want = tokens_due.pop_front();
        if (tok_ch.kind !== want.kind || tok_ch.char_out !== want.ch ||
            tok_ch.error_cause !== want.cause)
          report($sformatf("kind %0d/%0d char %02h/%02h cause %0d/%0d (got/want)",
                           tok_ch.kind, want.kind, tok_ch.char_out, want.ch,
                           tok_ch.error_cause, want.cause));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    byte_ch.valid        = 1'b0;
    byte_ch.byte_in      = 8'h00;
    byte_ch.end_of_input = 1'b0;
    tok_ch.ready         = 1'b0;
    rst          = 1'b1;
    scan_ph      = S_BETWEEN;
    kept         = '0;
    in_count     = 0;
    send_gap     = 0;
    sink_gap     = 0;
    long_hold    = 0;
    hold_done    = 1'b0;
    quiet_cycles = 0;
    mismatches   = 0;
    drain_next   = 1'b0;

    // shortest name, next line straight after the closing quote
    add_text("A='z'");
    // every blank kind but the line feed around '=', empty value
    add_text("z_0-9 ");
    add(8'h0B);
    add(8'h0C);
    add(qkvls_pkg::CHAR_EQUALS);
    add(8'h0D);
    add_text("\t''\n");
    // longest name ended by '=', longest value finishing on escapes
    add(qkvls_pkg::CHAR_UNDERSCORE);
    for (int i = 1; i < NAME_LIM; i++) add(i[0] ? qkvls_pkg::CHAR_DASH : 8'h61 + 8'(i / 2));
    add(qkvls_pkg::CHAR_EQUALS);
    add(qkvls_pkg::CHAR_QUOTE);
    add(8'h00);
    add(8'hFF);
    add(8'h80);
    add(8'h7F);
    repeat (VAL_LIM - 8) add(rand_plain());
    add(qkvls_pkg::CHAR_BACKSLASH);
    add(qkvls_pkg::CHAR_QUOTE);
    add(qkvls_pkg::CHAR_BACKSLASH);
    add(qkvls_pkg::CHAR_BACKSLASH);
    add(8'h61);
    add(qkvls_pkg::CHAR_BACKSLASH);
    add(8'hFF);
    add(qkvls_pkg::CHAR_QUOTE);

    // sender waits for every token before the random part
    drain_next = 1'b1;
    while (bytes_to_send.size() < RANDOM_BYTES)
      add_line(($urandom_range(0, 19) == 0) ? NAME_LIM : $urandom_range(1, 8),
               ($urandom_range(0, 19) == 0) ? VAL_LIM : $urandom_range(0, 12));
    add_ending();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_to_send.size() != 0 || byte_ch.valid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
